// ----- rtl/core/mdu_pkg.sv -----
package mdu_pkg;

    // fixed field widths of the stream payload
    localparam int FIELD_W = 16;
    localparam int OUT_W   = 16;

    // signed output range
    localparam int OUT_MAX = 32767;
    localparam int OUT_MIN = -32768;

endpackage

// ----- rtl/core/motion_direction_unit_vector_top.sv -----
// Unit direction of motion between a previous and a current box.
// Slave stream: one beat carries both boxes (eight unsigned coordinates).
// Master stream: one beat carries the signed direction (dir_y, dir_x) with
// DIR_FRAC_BITS fraction bits; 1 << DIR_FRAC_BITS is 1.0. No motion gives 0, 0.
// Throughput: one beat per cycle, sustained, as long as the master side takes
// beats. Every stage of the pipeline is a cell with its own valid bit.
// Pipeline: the prep stages, R = COORD_BITS + 2 + DIR_FRAC_BITS square-root
// cells (one root bit each), Q = DIR_FRAC_BITS + 2 divider cells (one
// quotient bit each, both components side by side) and the output register.
// COORD_BITS above 16 acts as 16.
// Reset empties every stage; nothing else is held across beats.
// A stalled master side fills the pipeline from the output end backward;
// s_tready drops only when every stage from the input to the output is full
// and the output beat is not taken.
module motion_direction_unit_vector_top #(
    parameter int COORD_BITS    = 16,
    parameter int DIR_FRAC_BITS = 14
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // prev_left, prev_top, prev_right, prev_bottom,
    // cur_left, cur_top, cur_right, cur_bottom (16 bits each)
    input  logic [8*mdu_pkg::FIELD_W-1:0] s_tdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // dir_y, dir_x (16 bits each)
    output logic [2*mdu_pkg::OUT_W-1:0]   m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready
);
    import mdu_pkg::*;

    localparam int CW     = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
    localparam int MAG_W  = CW + 1;
    localparam int RAD_W  = 2 * CW + 4;
    localparam int ROOT_W = CW + 2 + DIR_FRAC_BITS;
    localparam int Q_W    = DIR_FRAC_BITS + 2;

    // square-root chain taps
    logic [ROOT_W:0]             sq_valid, sq_ready;
    logic [ROOT_W:0][RAD_W-1:0]  sq_rad;
    logic [ROOT_W:0][ROOT_W:0]   sq_rem;
    logic [ROOT_W:0][ROOT_W-1:0] sq_root;
    logic [ROOT_W:0][MAG_W-1:0]  sq_ay, sq_ax;
    logic [ROOT_W:0]             sq_sy, sq_sx, sq_zero;

    // divider chain taps
    logic [Q_W:0]                dv_valid, dv_ready;
    logic [Q_W:0][ROOT_W-1:0]    dv_div, dv_ry, dv_rx;
    logic [Q_W:0][Q_W-1:0]       dv_qy, dv_qx;
    logic [Q_W:0]                dv_sy, dv_sx, dv_zero;

    logic [OUT_W-1:0]            dir_y, dir_x;

    // centers, differences and squared length
    mdu_prep #(
        .COORD_W (CW)
    ) u_prep (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .prev_left   (s_tdata[0*FIELD_W +: FIELD_W]),
        .prev_top    (s_tdata[1*FIELD_W +: FIELD_W]),
        .prev_right  (s_tdata[2*FIELD_W +: FIELD_W]),
        .prev_bottom (s_tdata[3*FIELD_W +: FIELD_W]),
        .cur_left    (s_tdata[4*FIELD_W +: FIELD_W]),
        .cur_top     (s_tdata[5*FIELD_W +: FIELD_W]),
        .cur_right   (s_tdata[6*FIELD_W +: FIELD_W]),
        .cur_bottom  (s_tdata[7*FIELD_W +: FIELD_W]),
        .out_valid   (sq_valid[0]),
        .out_ready   (sq_ready[0]),
        .mag_y       (sq_ay[0]),
        .mag_x       (sq_ax[0]),
        .neg_y       (sq_sy[0]),
        .neg_x       (sq_sx[0]),
        .no_motion   (sq_zero[0]),
        .dist2       (sq_rad[0])
    );

    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    // root of dist2 << 2*DIR_FRAC_BITS, one bit per cell
    for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
        mdu_sqrt_cell #(
            .MAG_W  (MAG_W),
            .RAD_W  (RAD_W),
            .ROOT_W (ROOT_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (sq_valid[i]),
            .in_ready  (sq_ready[i]),
            .rad_in    (sq_rad[i]),
            .rem_in    (sq_rem[i]),
            .root_in   (sq_root[i]),
            .ay_in     (sq_ay[i]),
            .ax_in     (sq_ax[i]),
            .sy_in     (sq_sy[i]),
            .sx_in     (sq_sx[i]),
            .zero_in   (sq_zero[i]),
            .out_valid (sq_valid[i+1]),
            .out_ready (sq_ready[i+1]),
            .rad_out   (sq_rad[i+1]),
            .rem_out   (sq_rem[i+1]),
            .root_out  (sq_root[i+1]),
            .ay_out    (sq_ay[i+1]),
            .ax_out    (sq_ax[i+1]),
            .sy_out    (sq_sy[i+1]),
            .sx_out    (sq_sx[i+1]),
            .zero_out  (sq_zero[i+1])
        );
    end

    // divider entry: partial remainder is the magnitude with the zero tail pre-shifted
    assign dv_valid[ROOT_W - ROOT_W] = sq_valid[ROOT_W];
    assign sq_ready[ROOT_W]          = dv_ready[0];
    assign dv_div[0]  = sq_root[ROOT_W];
    assign dv_ry[0]   = ROOT_W'(sq_ay[ROOT_W]) << (DIR_FRAC_BITS - 2);
    assign dv_rx[0]   = ROOT_W'(sq_ax[ROOT_W]) << (DIR_FRAC_BITS - 2);
    assign dv_qy[0]   = '0;
    assign dv_qx[0]   = '0;
    assign dv_sy[0]   = sq_sy[ROOT_W];
    assign dv_sx[0]   = sq_sx[ROOT_W];
    assign dv_zero[0] = sq_zero[ROOT_W];

    // quotient bits, both components per cell
    for (genvar j = 0; j < Q_W; j++) begin : g_div
        mdu_div_cell #(
            .ROOT_W (ROOT_W),
            .Q_W    (Q_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (dv_valid[j]),
            .in_ready  (dv_ready[j]),
            .div_in    (dv_div[j]),
            .ry_in     (dv_ry[j]),
            .rx_in     (dv_rx[j]),
            .qy_in     (dv_qy[j]),
            .qx_in     (dv_qx[j]),
            .sy_in     (dv_sy[j]),
            .sx_in     (dv_sx[j]),
            .zero_in   (dv_zero[j]),
            .out_valid (dv_valid[j+1]),
            .out_ready (dv_ready[j+1]),
            .div_out   (dv_div[j+1]),
            .ry_out    (dv_ry[j+1]),
            .rx_out    (dv_rx[j+1]),
            .qy_out    (dv_qy[j+1]),
            .qx_out    (dv_qx[j+1]),
            .sy_out    (dv_sy[j+1]),
            .sx_out    (dv_sx[j+1]),
            .zero_out  (dv_zero[j+1])
        );
    end

    // clamp, sign and output register
    mdu_out #(
        .FRAC_BITS (DIR_FRAC_BITS),
        .Q_W       (Q_W)
    ) u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dv_valid[Q_W]),
        .in_ready  (dv_ready[Q_W]),
        .qy        (dv_qy[Q_W]),
        .qx        (dv_qx[Q_W]),
        .sy        (dv_sy[Q_W]),
        .sx        (dv_sx[Q_W]),
        .zero      (dv_zero[Q_W]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .dir_y     (dir_y),
        .dir_x     (dir_x)
    );

    assign m_tdata = {dir_x, dir_y};

endmodule

// ----- rtl/core/mdu_prep.sv -----
module mdu_prep #(
    parameter int COORD_W = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [mdu_pkg::FIELD_W-1:0] prev_left,
    input  logic [mdu_pkg::FIELD_W-1:0] prev_top,
    input  logic [mdu_pkg::FIELD_W-1:0] prev_right,
    input  logic [mdu_pkg::FIELD_W-1:0] prev_bottom,
    input  logic [mdu_pkg::FIELD_W-1:0] cur_left,
    input  logic [mdu_pkg::FIELD_W-1:0] cur_top,
    input  logic [mdu_pkg::FIELD_W-1:0] cur_right,
    input  logic [mdu_pkg::FIELD_W-1:0] cur_bottom,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [COORD_W:0]            mag_y,
    output logic [COORD_W:0]            mag_x,
    output logic                        neg_y,
    output logic                        neg_x,
    output logic                        no_motion,
    output logic [2*COORD_W+3:0]        dist2
);
    import mdu_pkg::*;

    localparam int MAG_W = COORD_W + 1;
    localparam int RAD_W = 2 * COORD_W + 4;

    // stage 1: doubled centers, absolute differences and signs
    logic             st1_valid_reg, st1_valid_next, st1_ready;
    logic [MAG_W-1:0] ay_reg, ax_reg, ay_next, ax_next;
    logic             sy_reg, sx_reg, sy_next, sx_next;
    logic [MAG_W-1:0] py, px, cy, cx;

    // stage 2: squared length
    logic             st2_valid_reg, st2_valid_next;
    logic [MAG_W-1:0] ay2_reg, ax2_reg;
    logic             sy2_reg, sx2_reg;
    logic             zero_reg, zero_next;
    logic [RAD_W-1:0] d2_reg, d2_next;

    assign py = MAG_W'(prev_top[COORD_W-1:0])  + MAG_W'(prev_bottom[COORD_W-1:0]);
    assign px = MAG_W'(prev_left[COORD_W-1:0]) + MAG_W'(prev_right[COORD_W-1:0]);
    assign cy = MAG_W'(cur_top[COORD_W-1:0])   + MAG_W'(cur_bottom[COORD_W-1:0]);
    assign cx = MAG_W'(cur_left[COORD_W-1:0])  + MAG_W'(cur_right[COORD_W-1:0]);

    always_comb begin
        sy_next = (cy < py);
        sx_next = (cx < px);
        ay_next = sy_next ? (py - cy) : (cy - py);
        ax_next = sx_next ? (px - cx) : (cx - px);
    end

    // stage handshakes: a stage takes a beat when empty or draining
    assign st1_ready      = !st2_valid_reg || out_ready;
    assign in_ready       = !st1_valid_reg || st1_ready;
    assign st1_valid_next = in_ready ? in_valid : st1_valid_reg;
    assign st2_valid_next = st1_ready ? st1_valid_reg : st2_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
        end else begin
            st1_valid_reg <= st1_valid_next;
            st2_valid_reg <= st2_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            ay_reg <= ay_next;
            ax_reg <= ax_next;
            sy_reg <= sy_next;
            sx_reg <= sx_next;
        end
    end

    // squares and their sum
    always_comb begin
        d2_next   = RAD_W'(ay_reg) * RAD_W'(ay_reg) + RAD_W'(ax_reg) * RAD_W'(ax_reg);
        zero_next = (ay_reg == '0) && (ax_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (st1_valid_reg && st1_ready) begin
            ay2_reg  <= ay_reg;
            ax2_reg  <= ax_reg;
            sy2_reg  <= sy_reg;
            sx2_reg  <= sx_reg;
            zero_reg <= zero_next;
            d2_reg   <= d2_next;
        end
    end

    assign out_valid = st2_valid_reg;
    assign mag_y     = ay2_reg;
    assign mag_x     = ax2_reg;
    assign neg_y     = sy2_reg;
    assign neg_x     = sx2_reg;
    assign no_motion = zero_reg;
    assign dist2     = d2_reg;

endmodule

// ----- rtl/core/mdu_sqrt_cell.sv -----
module mdu_sqrt_cell #(
    parameter int MAG_W  = 17,
    parameter int RAD_W  = 36,
    parameter int ROOT_W = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [RAD_W-1:0]  rad_in,
    input  logic [ROOT_W:0]   rem_in,
    input  logic [ROOT_W-1:0] root_in,
    input  logic [MAG_W-1:0]  ay_in,
    input  logic [MAG_W-1:0]  ax_in,
    input  logic              sy_in,
    input  logic              sx_in,
    input  logic              zero_in,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [RAD_W-1:0]  rad_out,
    output logic [ROOT_W:0]   rem_out,
    output logic [ROOT_W-1:0] root_out,
    output logic [MAG_W-1:0]  ay_out,
    output logic [MAG_W-1:0]  ax_out,
    output logic              sy_out,
    output logic              sx_out,
    output logic              zero_out
);
    import mdu_pkg::*;

    logic              valid_reg, valid_next;
    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [ROOT_W:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [MAG_W-1:0]  ay_reg, ax_reg;
    logic              sy_reg, sx_reg, zero_reg;
    logic [ROOT_W+2:0] rem_sh, trial, diff;
    logic              fits;

    // one root bit: bring down two radicand bits, try root*4+1
    always_comb begin
        rem_sh    = {rem_in, rad_in[RAD_W-1 -: 2]};
        trial     = {1'b0, root_in, 2'b01};
        diff      = rem_sh - trial;
        fits      = (rem_sh >= trial);
        rem_next  = fits ? diff[ROOT_W:0] : rem_sh[ROOT_W:0];
        root_next = {root_in[ROOT_W-2:0], fits};
        rad_next  = {rad_in[RAD_W-3:0], 2'b00};
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            ay_reg   <= ay_in;
            ax_reg   <= ax_in;
            sy_reg   <= sy_in;
            sx_reg   <= sx_in;
            zero_reg <= zero_in;
        end
    end

    assign out_valid = valid_reg;
    assign rad_out   = rad_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;
    assign ay_out    = ay_reg;
    assign ax_out    = ax_reg;
    assign sy_out    = sy_reg;
    assign sx_out    = sx_reg;
    assign zero_out  = zero_reg;

endmodule

// ----- rtl/core/mdu_div_cell.sv -----
module mdu_div_cell #(
    parameter int ROOT_W = 32,
    parameter int Q_W    = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [ROOT_W-1:0] div_in,
    input  logic [ROOT_W-1:0] ry_in,
    input  logic [ROOT_W-1:0] rx_in,
    input  logic [Q_W-1:0]    qy_in,
    input  logic [Q_W-1:0]    qx_in,
    input  logic              sy_in,
    input  logic              sx_in,
    input  logic              zero_in,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ROOT_W-1:0] div_out,
    output logic [ROOT_W-1:0] ry_out,
    output logic [ROOT_W-1:0] rx_out,
    output logic [Q_W-1:0]    qy_out,
    output logic [Q_W-1:0]    qx_out,
    output logic              sy_out,
    output logic              sx_out,
    output logic              zero_out
);
    import mdu_pkg::*;

    logic              valid_reg, valid_next;
    logic [ROOT_W-1:0] div_reg;
    logic [ROOT_W-1:0] ry_reg, rx_reg, ry_next, rx_next;
    logic [Q_W-1:0]    qy_reg, qx_reg, qy_next, qx_next;
    logic              sy_reg, sx_reg, zero_reg;
    logic [ROOT_W:0]   ys, xs, yd, xd, dv;
    logic              y_ge, x_ge;

    // one restoring quotient bit for each lane; dividend tail bits are zero
    always_comb begin
        dv      = {1'b0, div_in};
        ys      = {ry_in, 1'b0};
        xs      = {rx_in, 1'b0};
        yd      = ys - dv;
        xd      = xs - dv;
        y_ge    = (ys >= dv);
        x_ge    = (xs >= dv);
        ry_next = y_ge ? yd[ROOT_W-1:0] : ys[ROOT_W-1:0];
        rx_next = x_ge ? xd[ROOT_W-1:0] : xs[ROOT_W-1:0];
        qy_next = {qy_in[Q_W-2:0], y_ge};
        qx_next = {qx_in[Q_W-2:0], x_ge};
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            div_reg  <= div_in;
            ry_reg   <= ry_next;
            rx_reg   <= rx_next;
            qy_reg   <= qy_next;
            qx_reg   <= qx_next;
            sy_reg   <= sy_in;
            sx_reg   <= sx_in;
            zero_reg <= zero_in;
        end
    end

    assign out_valid = valid_reg;
    assign div_out   = div_reg;
    assign ry_out    = ry_reg;
    assign rx_out    = rx_reg;
    assign qy_out    = qy_reg;
    assign qx_out    = qx_reg;
    assign sy_out    = sy_reg;
    assign sx_out    = sx_reg;
    assign zero_out  = zero_reg;

endmodule

// ----- rtl/core/mdu_out.sv -----
module mdu_out #(
    parameter int FRAC_BITS = 14,
    parameter int Q_W       = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [Q_W-1:0]            qy,
    input  logic [Q_W-1:0]            qx,
    input  logic                      sy,
    input  logic                      sx,
    input  logic                      zero,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [mdu_pkg::OUT_W-1:0] dir_y,
    output logic [mdu_pkg::OUT_W-1:0] dir_x
);
    import mdu_pkg::*;

    localparam int V_W = (Q_W + 1 > OUT_W) ? Q_W + 1 : OUT_W;
    localparam logic [Q_W-1:0]        ONE  = Q_W'(1) << FRAC_BITS;
    localparam logic signed [V_W-1:0] VMAX = V_W'(OUT_MAX);
    localparam logic signed [V_W-1:0] VMIN = V_W'(OUT_MIN);

    logic             valid_reg, valid_next;
    logic [OUT_W-1:0] dy_reg, dx_reg, dy_next, dx_next;

    // clamp to 1.0, apply sign, saturate to the output width
    function automatic logic [OUT_W-1:0] finish(input logic [Q_W-1:0] q, input logic neg);
        logic [Q_W-1:0]        qc;
        logic signed [V_W-1:0] v;
        qc = (q > ONE) ? ONE : q;
        v  = neg ? -$signed(V_W'(qc)) : $signed(V_W'(qc));
        if (v > VMAX) begin
            v = VMAX;
        end else if (v < VMIN) begin
            v = VMIN;
        end
        return v[OUT_W-1:0];
    endfunction

    always_comb begin
        dy_next = zero ? '0 : finish(qy, sy);
        dx_next = zero ? '0 : finish(qx, sx);
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            dy_reg <= dy_next;
            dx_reg <= dx_next;
        end
    end

    assign out_valid = valid_reg;
    assign dir_y     = dy_reg;
    assign dir_x     = dx_reg;

endmodule

// ----- tb/sv/tb_motion_direction_unit_vector_top.sv -----
module tb_motion_direction_unit_vector_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mdu_pkg::*;

    localparam int FRAC        = 14;      // fraction bits of the direction
    localparam int N_DIRECTED  = 19;
    localparam int N_RANDOM    = 1750;
    localparam int DRAIN_WAIT  = 100;     // pipeline is 51 deep
    localparam int CYCLE_LIMIT = 200000;

    // one slave beat: first field in the lowest bits
    typedef struct packed {
        logic [FIELD_W-1:0] cur_bottom;
        logic [FIELD_W-1:0] cur_right;
        logic [FIELD_W-1:0] cur_top;
        logic [FIELD_W-1:0] cur_left;
        logic [FIELD_W-1:0] prev_bottom;
        logic [FIELD_W-1:0] prev_right;
        logic [FIELD_W-1:0] prev_top;
        logic [FIELD_W-1:0] prev_left;
    } box_pair_t;

    // one master beat: dir_y low, dir_x high
    typedef struct packed {
        logic signed [OUT_W-1:0] dir_x;
        logic signed [OUT_W-1:0] dir_y;
    } dir_t;

    typedef struct {
        box_pair_t beat;
        bit        known;
        dir_t      want;
    } step_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    box_pair_t            s_tdata  = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [2*OUT_W-1:0]   m_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;

    dir_t direction_fifo[$];
    int   errors     = 0;
    int   cycles     = 0;
    bit   calm_send  = 1'b0;
    bit   calm_recv  = 1'b0;

    motion_direction_unit_vector_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always #10 aclk = ~aclk;

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL motion_direction_unit_vector_top");
            $finish;
        end
    end

    // scale one displacement by the root, clamp to 1.0, saturate to 16 bits
    function automatic logic [OUT_W-1:0] scale_component(longint d,
                                                         longint unsigned root);
        longint unsigned mag;
        longint unsigned q;
        longint          v;
        mag = (d < 0) ? longint'(-d) : longint'(d);
        q = (mag << (2 * FRAC)) / root;
        if (q > (64'd1 << FRAC))
            q = 64'd1 << FRAC;
        v = (d < 0) ? -$signed(q) : $signed(q);
        if (v > OUT_MAX)
            v = OUT_MAX;
        if (v < OUT_MIN)
            v = OUT_MIN;
        return v[OUT_W-1:0];
    endfunction

    // unit direction from the doubled center displacement
    function automatic dir_t predict_direction(box_pair_t b);
        longint          dy;
        longint          dx;
        longint unsigned ay;
        longint unsigned ax;
        longint unsigned d2;
        longint unsigned root;
        longint unsigned trial;
        bit [127:0]      num;
        bit [127:0]      sq;
        dir_t            r;
        dy = (longint'(b.cur_top) + longint'(b.cur_bottom))
           - (longint'(b.prev_top) + longint'(b.prev_bottom));
        dx = (longint'(b.cur_left) + longint'(b.cur_right))
           - (longint'(b.prev_left) + longint'(b.prev_right));
        ay = (dy < 0) ? longint'(-dy) : longint'(dy);
        ax = (dx < 0) ? longint'(-dx) : longint'(dx);
        d2 = ay * ay + ax * ax;
        r = '0;
        if (d2 == 0)
            return r;
        // floor(sqrt(d2 << 2F)), one root bit at a time
        num = 128'(d2) << (2 * FRAC);
        root = 0;
        for (int k = 39; k >= 0; k--) begin
            trial = root | (64'd1 << k);
            sq = 128'(trial) * 128'(trial);
            if (sq <= num)
                root = trial;
        end
        if (root == 0)
            root = 1;
        r.dir_y = scale_component(dy, root);
        r.dir_x = scale_component(dx, root);
        return r;
    endfunction

    function automatic step_t make_step(int pl, int pt, int pr, int pb,
                                        int cl, int ct, int cr, int cb,
                                        bit known, int wy, int wx);
        step_t s;
        s.beat.prev_left   = 16'(pl);
        s.beat.prev_top    = 16'(pt);
        s.beat.prev_right  = 16'(pr);
        s.beat.prev_bottom = 16'(pb);
        s.beat.cur_left    = 16'(cl);
        s.beat.cur_top     = 16'(ct);
        s.beat.cur_right   = 16'(cr);
        s.beat.cur_bottom  = 16'(cb);
        s.known      = known;
        s.want.dir_y = 16'(wy);
        s.want.dir_x = 16'(wx);
        return s;
    endfunction

    // drive one box pair, record its direction when the beat is taken
    task automatic send_pair(input box_pair_t b, input bit known, input dir_t want);
        int gap;
        s_tdata  <= b;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        direction_fifo.push_back(known ? want : predict_direction(b));
        if ($urandom_range(0, 39) == 0)
            calm_send = !calm_send;
        gap = calm_send ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // hold the sender off until the pipeline has drained
    task automatic drain_directions();
        s_tvalid <= 1'b0;
        while (direction_fifo.size() != 0)
            @(posedge aclk);
    endtask

    // result side: random stalls, check every beat against the oldest entry
    initial begin
        dir_t got;
        dir_t want;
        int   stall;
        while (aresetn !== 1'b1)
            @(posedge aclk);
        forever begin
            if ($urandom_range(0, 39) == 0)
                calm_recv = !calm_recv;
            stall = calm_recv ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (m_tvalid !== 1'b1)
                @(posedge aclk);
            got = m_tdata;
            if (direction_fifo.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat, actual y=%0d x=%0d",
                         $time, got.dir_y, got.dir_x);
            end else begin
                want = direction_fifo.pop_front();
                if (got.dir_y !== want.dir_y) begin
                    errors++;
                    $display("%0t: dir_y expected %0d actual %0d",
                             $time, want.dir_y, got.dir_y);
                end
                if (got.dir_x !== want.dir_x) begin
                    errors++;
                    $display("%0t: dir_x expected %0d actual %0d",
                             $time, want.dir_x, got.dir_x);
                end
            end
        end
    end

    // stimulus
    initial begin
        step_t     steps [N_DIRECTED];
        box_pair_t b;
        int        kind;
        int        px;
        int        py;
        int        d;

        // pl, pt, pr, pb, cl, ct, cr, cb, known, dir_y, dir_x
        steps = '{
            make_step(0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0),                 // no motion
            make_step('hFFFF, 'hFFFF, 'hFFFF, 'hFFFF,
                      'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 1, 0, 0),
            make_step(0, 0, 0, 0, 0, 'hFFFF, 0, 'hFFFF, 1, 16384, 0),   // full down
            make_step(0, 'hFFFF, 0, 'hFFFF, 0, 0, 0, 0, 1, -16384, 0),  // full up
            make_step(0, 0, 0, 0, 'hFFFF, 0, 'hFFFF, 0, 1, 0, 16384),   // full right
            make_step('hFFFF, 0, 'hFFFF, 0, 0, 0, 0, 0, 1, 0, -16384),  // full left
            make_step(0, 0, 0, 0, 0, 1, 0, 0, 1, 16384, 0),             // one lsb
            make_step(1, 0, 0, 0, 0, 0, 0, 0, 1, 0, -16384),
            make_step(0, 0, 0, 0, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 0, 0, 0),
            make_step('hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 0, 0, 0, 0, 0, 0, 0),
            make_step(1234, 4321, 2345, 5432, 1234, 4321, 2345, 5432, 1, 0, 0),
            make_step(100, 200, 300, 400, 150, 250, 250, 350, 1, 0, 0), // same center
            make_step(0, 0, 0, 0, 2, 3, 2, 0, 0, 0, 0),                 // 3-4-5
            make_step(0, 3, 4, 0, 0, 0, 0, 0, 0, 0, 0),
            make_step(0, 0, 0, 0, 1, 1, 0, 0, 0, 0, 0),                 // diagonal lsb
            make_step(0, 0, 0, 0, 1, 'hFFFF, 0, 'hFFFF, 0, 0, 0),       // near-axis
            make_step('hAAAA, 'h5555, 'hAAAA, 'h5555,
                      'h5555, 'hAAAA, 'h5555, 'hAAAA, 0, 0, 0),
            make_step('hFFFF, 0, 'hFFFE, 1, 0, 'hFFFF, 1, 'hFFFE, 0, 0, 0),
            make_step('h8000, 'h7FFF, 'h8000, 'h7FFF,
                      'h7FFF, 'h8000, 'h7FFF, 'h8000, 0, 0, 0)
        };

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (steps[i])
            send_pair(steps[i].beat, steps[i].known, steps[i].want);
        drain_directions();

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 2)
                drain_directions();
            b = {$urandom, $urandom, $urandom, $urandom};
            kind = $urandom_range(0, 9);
            case (kind)
                5, 6: begin
                    // small motion around a random box
                    b.cur_left   = b.prev_left   + 16'($urandom_range(0, 16) - 8);
                    b.cur_top    = b.prev_top    + 16'($urandom_range(0, 16) - 8);
                    b.cur_right  = b.prev_right  + 16'($urandom_range(0, 16) - 8);
                    b.cur_bottom = b.prev_bottom + 16'($urandom_range(0, 16) - 8);
                end
                7: begin
                    // box resized about an unchanged center
                    px = int'(b.prev_left) + int'(b.prev_right);
                    py = int'(b.prev_top) + int'(b.prev_bottom);
                    b.cur_left = 16'($urandom_range(px > 65535 ? px - 65535 : 0,
                                                    px > 65535 ? 65535 : px));
                    b.cur_right = 16'(px - int'(b.cur_left));
                    b.cur_top = 16'($urandom_range(py > 65535 ? py - 65535 : 0,
                                                   py > 65535 ? 65535 : py));
                    b.cur_bottom = 16'(py - int'(b.cur_top));
                end
                8: begin
                    // coordinates at the range ends
                    for (int f = 0; f < 8; f++) begin
                        case ($urandom_range(0, 3))
                            0: b[f*FIELD_W +: FIELD_W] = 16'h0000;
                            1: b[f*FIELD_W +: FIELD_W] = 16'h0001;
                            2: b[f*FIELD_W +: FIELD_W] = 16'hFFFE;
                            default: b[f*FIELD_W +: FIELD_W] = 16'hFFFF;
                        endcase
                    end
                end
                9: begin
                    // motion along one axis only
                    d = $urandom_range(0, 600) - 300;
                    b.cur_left   = b.prev_left;
                    b.cur_top    = b.prev_top;
                    b.cur_right  = b.prev_right;
                    b.cur_bottom = b.prev_bottom;
                    if ($urandom_range(0, 1) == 1)
                        b.cur_top = b.prev_top + 16'(d);
                    else
                        b.cur_right = b.prev_right + 16'(d);
                end
                default: ;
            endcase
            send_pair(b, 1'b0, '0);
        end

        // wind down
        s_tvalid <= 1'b0;
        while (direction_fifo.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (errors == 0)
            $display("PASS motion_direction_unit_vector_top");
        else
            $display("FAIL motion_direction_unit_vector_top");
        $finish;
    end

endmodule
